// ----- design/box_obstacle_proximity_check_defines.svh -----
// Assertion macros used by the proximity checker datapath.
// Depends on nothing; the including module must provide clk and arst_n.
`ifndef BOX_OBSTACLE_PROXIMITY_CHECK_DEFINES_SVH
`define BOX_OBSTACLE_PROXIMITY_CHECK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BOPC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BOPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/bopc_pkg.sv -----
// Package for the box obstacle proximity checker: sizes, field layout,
// command codes, cube bound record and the sequencer microcode. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bopc_pkg;

	// Table depth and coordinate width.
	localparam int MAX_BOXES  = 8;
	localparam int COORD_BITS = 24;
	localparam int LEN_BITS   = COORD_BITS - 1;
	localparam int BOUND_BITS = COORD_BITS + 2;

	// Table index and fill count widths.
	localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CNT_W = $clog2(MAX_BOXES + 1);

	// Input item layout in tdata, lowest field first.
	localparam int POS_X_LSB  = 0;
	localparam int POS_Y_LSB  = COORD_BITS;
	localparam int POS_Z_LSB  = 2 * COORD_BITS;
	localparam int SIDE_LSB   = 3 * COORD_BITS;
	localparam int MARGIN_LSB = 3 * COORD_BITS + LEN_BITS;
	localparam int IN_BITS    = 3 * COORD_BITS + 2 * LEN_BITS;
	localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int S_TUSER_W  = 2;
	localparam int M_TDATA_W  = 8;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [LEN_BITS-1:0]          len_t;
	typedef logic signed [BOUND_BITS-1:0] bound_t;
	typedef logic [IDX_W-1:0]             idx_t;
	typedef logic [CNT_W-1:0]             cnt_t;

	// Command codes carried in tuser.
	typedef enum logic [1:0] {
		CMD_QUERY = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	// Six bounds of one stored cube.
	typedef struct packed {
		logic signed [BOUND_BITS-1:0] lo_x;
		logic signed [BOUND_BITS-1:0] hi_x;
		logic signed [BOUND_BITS-1:0] lo_y;
		logic signed [BOUND_BITS-1:0] hi_y;
		logic signed [BOUND_BITS-1:0] lo_z;
		logic signed [BOUND_BITS-1:0] hi_z;
	} box_t;

	// Program steps.
	typedef enum logic [2:0] {
		ST_WAIT  = 3'd0,
		ST_PREP  = 3'd1,
		ST_SCAN  = 3'd2,
		ST_ADD   = 3'd3,
		ST_CLEAR = 3'd4,
		ST_EMIT  = 3'd5
	} step_t;

	// Datapath operation selected by a control word.
	typedef enum logic [2:0] {
		OP_NOP   = 3'd0,
		OP_WAIT  = 3'd1,
		OP_PREP  = 3'd2,
		OP_SCAN  = 3'd3,
		OP_ADD   = 3'd4,
		OP_CLEAR = 3'd5,
		OP_EMIT  = 3'd6
	} op_t;

	// How the step counter moves on.
	typedef enum logic [1:0] {
		JMP_ALWAYS   = 2'd0,
		JMP_DISPATCH = 2'd1,
		JMP_IF_DONE  = 2'd2,
		JMP_IF_FREE  = 2'd3
	} jmp_t;

	typedef struct packed {
		op_t   op;
		jmp_t  jmp;
		step_t target;
	} ctrl_word_t;

	// Conditions the sequencer branches on.
	typedef struct packed {
		logic accept;
		cmd_t cmd;
		logic scan_done;
		logic out_free;
	} seq_stat_t;

	// Microcode store: one control word per step.
	function automatic ctrl_word_t ucode_rom(input step_t step);
		ctrl_word_t w;
		case (step)
			ST_WAIT:  w = '{op: OP_WAIT,  jmp: JMP_DISPATCH, target: ST_WAIT};
			ST_PREP:  w = '{op: OP_PREP,  jmp: JMP_ALWAYS,   target: ST_SCAN};
			ST_SCAN:  w = '{op: OP_SCAN,  jmp: JMP_IF_DONE,  target: ST_EMIT};
			ST_ADD:   w = '{op: OP_ADD,   jmp: JMP_ALWAYS,   target: ST_EMIT};
			ST_CLEAR: w = '{op: OP_CLEAR, jmp: JMP_ALWAYS,   target: ST_EMIT};
			ST_EMIT:  w = '{op: OP_EMIT,  jmp: JMP_IF_FREE,  target: ST_WAIT};
			default:  w = '{op: OP_NOP,   jmp: JMP_ALWAYS,   target: ST_WAIT};
		endcase
		return w;
	endfunction

	// Entry step for each command; an unused code goes straight to the result.
	function automatic step_t dispatch_step(input cmd_t cmd);
		step_t s;
		case (cmd)
			CMD_QUERY: s = ST_PREP;
			CMD_ADD:   s = ST_ADD;
			CMD_CLEAR: s = ST_CLEAR;
			default:   s = ST_EMIT;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ----- design/box_obstacle_proximity_check.sv -----
// Top level of the box obstacle proximity checker: stream ports, sequencer,
// datapath and result register. Depends on bopc_pkg, bopc_sequencer, bopc_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Holds up to MAX_BOXES axis-aligned cubes and answers one item at a time with
// exactly one result item. A query goes through acceptance, widening of the
// point by the margin, a scan with one stored cube compared per cycle through
// the bound table's registered read port until a hit or a closing step, and
// then the load of the result register; add and clear pass through their own
// step to that load, and the unused command goes straight to it. A result may
// wait in the output register while the next item is accepted and worked on.

module box_obstacle_proximity_check
	import bopc_pkg::*;
(
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    s_tvalid,
	output logic                   s_tready,
	// pos_x, pos_y, pos_z, side_len, margin, zero padding
	input  wire  [S_TDATA_W-1:0]   s_tdata,
	// command
	input  wire  [S_TUSER_W-1:0]   s_tuser,
	output logic                   m_tvalid,
	input  wire                    m_tready,
	// near_hit, status, zero padding
	output logic [M_TDATA_W-1:0]   m_tdata
);

	ctrl_word_t ctrl;
	seq_stat_t  stat;
	logic       s_fire;
	logic       out_free;
	logic       scan_done;
	logic       near_hit;
	logic       status;
	logic       out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;

	// Items are taken only in the waiting step.
	assign s_tready = (ctrl.op == OP_WAIT);
	assign s_fire   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		stat.accept    = s_fire;
		stat.cmd       = cmd_t'(s_tuser);
		stat.scan_done = scan_done;
		stat.out_free  = out_free;
	end

	bopc_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	bopc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.accept    (s_fire),
		.cmd       (cmd_t'(s_tuser)),
		.pos_x     (s_tdata[POS_X_LSB +: COORD_BITS]),
		.pos_y     (s_tdata[POS_Y_LSB +: COORD_BITS]),
		.pos_z     (s_tdata[POS_Z_LSB +: COORD_BITS]),
		.side_len  (s_tdata[SIDE_LSB +: LEN_BITS]),
		.margin    (s_tdata[MARGIN_LSB +: LEN_BITS]),
		.scan_done (scan_done),
		.near_hit  (near_hit),
		.status    (status)
	);

	// Result register: loaded in the emit step once the previous item has left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((ctrl.op == OP_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((ctrl.op == OP_EMIT) && out_free) begin
			out_data_q <= {{(M_TDATA_W - 2){1'b0}}, status, near_hit};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

// ----- design/bopc_box_store.sv -----
// Cube bound table: one write port and one registered read port.
// Depends on bopc_pkg for the bound record and index width.
`timescale 1ns / 1ps
`default_nettype none

module bopc_box_store
	import bopc_pkg::*;
(
	input  wire  clk,
	input  wire  wr_en,
	input  idx_t wr_addr,
	input  box_t wr_data,
	input  idx_t rd_addr,
	output box_t rd_data
);

	box_t mem_q [MAX_BOXES];
	box_t rd_data_q;

	// Entries hold no reset value; only written entries are ever compared.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read.
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- design/bopc_sequencer.sv -----
// Microcode sequencer: step counter, control store lookup and branch logic.
// Depends on bopc_pkg for the step, control word and status types.
`timescale 1ns / 1ps
`default_nettype none

module bopc_sequencer
	import bopc_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  seq_stat_t  stat,
	output ctrl_word_t ctrl
);

	step_t step_q;
	step_t step_d;

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_WAIT;
		end else begin
			step_q <= step_d;
		end
	end

	// Control word for this step and the branch to the next one.
	always_comb begin
		ctrl   = ucode_rom(step_q);
		step_d = step_q;
		case (ctrl.jmp)
			JMP_ALWAYS: begin
				step_d = ctrl.target;
			end
			JMP_DISPATCH: begin
				if (stat.accept) begin
					step_d = dispatch_step(stat.cmd);
				end
			end
			JMP_IF_DONE: begin
				if (stat.scan_done) begin
					step_d = ctrl.target;
				end
			end
			JMP_IF_FREE: begin
				if (stat.out_free) begin
					step_d = ctrl.target;
				end
			end
			default: begin
				step_d = ST_WAIT;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- design/bopc_datapath.sv -----
// Datapath: operand registers, bound arithmetic, scan compare, fill count
// and result flags. Depends on bopc_pkg, bopc_box_store and the defines header.
`timescale 1ns / 1ps
`default_nettype none

`include "box_obstacle_proximity_check_defines.svh"

module bopc_datapath
	import bopc_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  ctrl_word_t ctrl,
	input  wire        accept,
	input  cmd_t       cmd,
	input  coord_t     pos_x,
	input  coord_t     pos_y,
	input  coord_t     pos_z,
	input  len_t       side_len,
	input  len_t       margin,
	output logic       scan_done,
	output logic       near_hit,
	output logic       status
);

	// Operands captured when the item is accepted.
	cmd_t   cmd_q;
	coord_t px_q, py_q, pz_q;
	len_t   half_q, margin_q;

	// Query point widened by the margin in each direction.
	bound_t plus_x_q, plus_y_q, plus_z_q;
	bound_t minus_x_q, minus_y_q, minus_z_q;

	// Control state.
	cnt_t   count_q;
	cnt_t   scan_idx_q;
	logic   rd_valid_q;
	logic   hit_q;
	logic   status_q;

	bound_t px_w, py_w, pz_w, half_w, margin_w;
	box_t   new_box;
	box_t   rd_box;
	idx_t   rd_addr;
	logic   wr_en;
	logic   table_full;
	logic   match;

	// Sign-extend the coordinates, zero-extend the lengths.
	always_comb begin
		px_w     = bound_t'(px_q);
		py_w     = bound_t'(py_q);
		pz_w     = bound_t'(pz_q);
		half_w   = {{(BOUND_BITS - LEN_BITS){1'b0}}, half_q};
		margin_w = {{(BOUND_BITS - LEN_BITS){1'b0}}, margin_q};
	end

	// Bounds of a new cube.
	always_comb begin
		new_box.lo_x = px_w - half_w;
		new_box.hi_x = px_w + half_w;
		new_box.lo_y = py_w - half_w;
		new_box.hi_y = py_w + half_w;
		new_box.lo_z = pz_w - half_w;
		new_box.hi_z = pz_w + half_w;
	end

	assign table_full = (count_q == cnt_t'(MAX_BOXES));
	assign wr_en      = (ctrl.op == OP_ADD) && !table_full;
	assign rd_addr    = (ctrl.op == OP_PREP) ? '0 : scan_idx_q[IDX_W-1:0];

	bopc_box_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (new_box),
		.rd_addr (rd_addr),
		.rd_data (rd_box)
	);

	// p lies strictly inside lo - m .. hi + m exactly when p + m > lo and p - m < hi.
	always_comb begin
		match = rd_valid_q
			&& (plus_x_q > $signed(rd_box.lo_x)) && (minus_x_q < $signed(rd_box.hi_x))
			&& (plus_y_q > $signed(rd_box.lo_y)) && (minus_y_q < $signed(rd_box.hi_y))
			&& (plus_z_q > $signed(rd_box.lo_z)) && (minus_z_q < $signed(rd_box.hi_z));
	end

	// The scan ends on a hit or once the entry just read lay beyond the fill count.
	assign scan_done = match || !rd_valid_q;

	// Operand and widened point registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd;
			px_q     <= pos_x;
			py_q     <= pos_y;
			pz_q     <= pos_z;
			half_q   <= side_len >> 1;
			margin_q <= margin;
		end
		if (ctrl.op == OP_PREP) begin
			plus_x_q  <= px_w + margin_w;
			plus_y_q  <= py_w + margin_w;
			plus_z_q  <= pz_w + margin_w;
			minus_x_q <= px_w - margin_w;
			minus_y_q <= py_w - margin_w;
			minus_z_q <= pz_w - margin_w;
		end
	end

	// Fill count, scan pointer and result flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			scan_idx_q <= '0;
			rd_valid_q <= 1'b0;
			hit_q      <= 1'b0;
			status_q   <= 1'b0;
		end else begin
			case (ctrl.op)
				OP_WAIT: begin
					if (accept) begin
						hit_q    <= 1'b0;
						status_q <= 1'b0;
					end
				end
				OP_PREP: begin
					scan_idx_q <= cnt_t'(1);
					rd_valid_q <= (count_q != '0);
				end
				OP_SCAN: begin
					hit_q      <= hit_q | match;
					rd_valid_q <= (scan_idx_q < count_q);
					scan_idx_q <= scan_idx_q + cnt_t'(1);
				end
				OP_ADD: begin
					if (table_full) begin
						status_q <= 1'b1;
					end else begin
						count_q <= count_q + cnt_t'(1);
					end
				end
				OP_CLEAR: begin
					count_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign near_hit = hit_q;
	assign status   = status_q;

	`BOPC_ASSERT_SAME(a_count_bound, 1'b1, count_q <= cnt_t'(MAX_BOXES), "fill count above table depth")
	`BOPC_ASSERT_SAME(a_status_add, status_q, cmd_q == CMD_ADD, "full status on an item that is no add")
	`BOPC_ASSERT_SAME(a_hit_query, hit_q, cmd_q == CMD_QUERY, "hit flag on an item that is no query")
	`BOPC_ASSERT_NEXT(a_full_hold, (ctrl.op == OP_ADD) && table_full, count_q == cnt_t'(MAX_BOXES), "refused add changed the table")

endmodule

`default_nettype wire
